// ----- rtl/mpc_pkg.sv -----
// Package for the Mandelbrot pixel color block: sizes, payload and control types,
// and the saturation helpers that the datapath uses.
// No dependencies.
package mpc_pkg;

   localparam int MAX_SIDE   = 4096;
   localparam int FRAC_BITS  = 24;

   localparam int CFG_SIDE_W = 13;
   localparam int COORD_W    = 12;
   localparam int FX_W       = 32;
   localparam int SCALE_W    = 31;
   localparam int ITER_W     = 7;
   localparam int BYTE_W     = 8;

   localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
   localparam int PROD_W     = SIDE_W + COORD_W;
   localparam int DEN_W      = 2 * SIDE_W;
   localparam int NUM_W      = PROD_W + FRAC_BITS;
   localparam int STEP_W     = $clog2(NUM_W + 1);
   localparam int SEG_NUM_W  = ITER_W + 3;
   localparam int BYTE_NUM_W = BYTE_W + ITER_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;
   localparam logic signed [63:0] FX_ONE  = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] FX_HALF = 64'sd1 <<< (FRAC_BITS - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH    = 3'd0,
      CSR_IMAGE_HEIGHT   = 3'd1,
      CSR_ZOOM_SCALE     = 3'd2,
      CSR_ESCAPE_LIMIT   = 3'd3,
      CSR_MAX_ITERATIONS = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } req_type;

   typedef struct packed {
      logic [ITER_W-1:0] iteration_count;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] red;
   } rsp_type;

   typedef enum logic [2:0] {
      DIV_A   = 3'd0,
      DIV_B   = 3'd1,
      DIV_SEG = 3'd2,
      DIV_P   = 3'd3,
      DIV_Q   = 3'd4
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        setup;
      logic        div_start;
      logic        div_wait;
      div_sel_type div_sel;
      logic        mul_c;
      logic        sat_c;
      logic        iter_add;
      logic        color;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic iter_go;
   } status_type;

   function automatic logic signed [FX_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [FX_W-1:0] r;
      if (v > SAT_MAX) r = FX_W'(SAT_MAX);
      else if (v < SAT_MIN) r = FX_W'(SAT_MIN);
      else r = v[FX_W-1:0];
      return r;
   endfunction

   function automatic logic signed [FX_W-1:0] fx_scale(input logic signed [63:0] p);
      return sat32(p >>> FRAC_BITS);
   endfunction

   function automatic logic signed [FX_W-1:0] sat_add(input logic signed [FX_W-1:0] a,
                                                      input logic signed [FX_W-1:0] b);
      logic signed [63:0] s;
      s = 64'(a) + 64'(b);
      return sat32(s);
   endfunction

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_SIDE_W-1:0] s);
      logic [SIDE_W-1:0] r;
      if (s < CFG_SIDE_W'(2)) r = SIDE_W'(2);
      else if (int'(s) > MAX_SIDE) r = SIDE_W'(MAX_SIDE);
      else r = SIDE_W'(s);
      return r;
   endfunction

endpackage

// ----- rtl/mpc_divider.sv -----
// Restoring divider, one quotient bit per cycle, step count set at start.
// Depends on mpc_pkg.
module mpc_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mpc_pkg::NUM_W-1:0]   num,
   input  logic [mpc_pkg::DEN_W-1:0]   den,
   input  logic [mpc_pkg::STEP_W-1:0]  steps,
   output logic                        done,
   output logic [mpc_pkg::NUM_W-1:0]   quot,
   output logic [mpc_pkg::DEN_W-1:0]   rem
);
   import mpc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  quot_ff, quot_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    rem_sh;
   logic [STEP_W-1:0] shamt;
   logic              fits;

   assign shamt  = STEP_W'(NUM_W) - steps;
   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         num_in  = num << shamt;
         quot_in = '0;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         quot_in = {quot_ff[NUM_W-2:0], fits};
         rem_in  = fits ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         cnt_in  = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ----- rtl/mpc_datapath.sv -----
// Datapath: configuration registers, coordinate mapping, escape iteration, color ramp.
// Depends on mpc_pkg and mpc_divider.
module mpc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  mpc_pkg::cmd_type               cmd,
   output mpc_pkg::status_type            status,
   input  mpc_pkg::req_type               req_data,
   output mpc_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [mpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mpc_pkg::CSR_DATA_W-1:0] csr_data
);
   import mpc_pkg::*;

   // configuration
   logic [CFG_SIDE_W-1:0] width_ff, height_ff;
   logic [SCALE_W-1:0]    zoom_ff, limit_ff;
   logic [ITER_W-1:0]     maxit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_SIDE_W'(640);
         height_ff <= CFG_SIDE_W'(480);
         zoom_ff   <= SCALE_W'(25165824);
         limit_ff  <= SCALE_W'(50331648);
         maxit_ff  <= ITER_W'(40);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:    width_ff  <= csr_data[CFG_SIDE_W-1:0];
            CSR_IMAGE_HEIGHT:   height_ff <= csr_data[CFG_SIDE_W-1:0];
            CSR_ZOOM_SCALE:     zoom_ff   <= csr_data[SCALE_W-1:0];
            CSR_ESCAPE_LIMIT:   limit_ff  <= csr_data[SCALE_W-1:0];
            CSR_MAX_ITERATIONS: maxit_ff  <= csr_data[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   logic [SIDE_W-1:0] w_side, h_side;
   assign w_side = clamp_side(width_ff);
   assign h_side = clamp_side(height_ff);

   // payload registers
   req_type                req_ff;
   logic [PROD_W-1:0]      wc_ff;
   logic [DEN_W-1:0]       den_a_ff;
   logic signed [FX_W-1:0] x_ff, y_ff, cr_ff, ci_ff, zr_ff, zi_ff, quad_ff;
   logic signed [63:0]     p0_ff, p1_ff, p2_ff;
   logic [ITER_W-1:0]      n_ff;
   logic [2:0]             seg_ff;
   logic [ITER_W-1:0]      r_ff;
   logic [BYTE_W-1:0]      pq_ff, qq_ff;
   rsp_type                rsp_ff;

   // shared divider
   logic [NUM_W-1:0]  div_num, div_quot;
   logic [DEN_W-1:0]  div_den, div_rem;
   logic [STEP_W-1:0] div_steps;
   logic              div_done;

   logic [SEG_NUM_W-1:0]  seven_n;
   logic [ITER_W-1:0]     qn, base;
   logic [BYTE_W-1:0]     k_p, k_q;
   logic                  use_qn;
   logic [BYTE_NUM_W-1:0] num_p, num_q;

   assign seven_n = SEG_NUM_W'({n_ff, 3'b000}) - SEG_NUM_W'(n_ff);
   assign qn      = maxit_ff - r_ff;

   // ramp table: scale of each interpolated byte and whether it falls or rises
   always_comb begin
      unique case (seg_ff)
         3'd0:    begin k_p = 8'd127; k_q = 8'd255; use_qn = 1'b0; end
         3'd1:    begin k_p = 8'd255; k_q = 8'd255; use_qn = 1'b0; end
         3'd2:    begin k_p = 8'd255; k_q = 8'd255; use_qn = 1'b1; end
         3'd3:    begin k_p = 8'd127; k_q = 8'd127; use_qn = 1'b1; end
         3'd4:    begin k_p = 8'd63;  k_q = 8'd127; use_qn = 1'b1; end
         3'd5:    begin k_p = 8'd128; k_q = 8'd128; use_qn = 1'b0; end
         default: begin k_p = 8'd64;  k_q = 8'd128; use_qn = 1'b1; end
      endcase
   end

   assign base  = use_qn ? qn : r_ff;
   assign num_p = BYTE_NUM_W'(k_p) * BYTE_NUM_W'(base);
   assign num_q = BYTE_NUM_W'(k_q) * BYTE_NUM_W'(base);

   always_comb begin
      unique case (cmd.div_sel)
         DIV_A: begin
            div_num   = {wc_ff, {FRAC_BITS{1'b0}}};
            div_den   = den_a_ff;
            div_steps = STEP_W'(NUM_W);
         end
         DIV_B: begin
            div_num   = NUM_W'({req_ff.row, {FRAC_BITS{1'b0}}});
            div_den   = DEN_W'(h_side - SIDE_W'(1));
            div_steps = STEP_W'(COORD_W + FRAC_BITS);
         end
         DIV_SEG: begin
            div_num   = NUM_W'(seven_n);
            div_den   = DEN_W'(maxit_ff);
            div_steps = STEP_W'(SEG_NUM_W);
         end
         DIV_P: begin
            div_num   = NUM_W'(num_p);
            div_den   = DEN_W'(maxit_ff);
            div_steps = STEP_W'(BYTE_NUM_W);
         end
         default: begin
            div_num   = NUM_W'(num_q);
            div_den   = DEN_W'(maxit_ff);
            div_steps = STEP_W'(BYTE_NUM_W);
         end
      endcase
   end

   mpc_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .steps (div_steps),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   logic signed [63:0] quot_ext;
   assign quot_ext = $signed({{(64-NUM_W){1'b0}}, div_quot});

   // multipliers: c scaling or the three squaring products
   logic signed [FX_W-1:0] m0a, m0b, m1a, m1b;
   always_comb begin
      if (cmd.mul_c) begin
         m0a = $signed({1'b0, zoom_ff}); m0b = x_ff;
         m1a = $signed({1'b0, zoom_ff}); m1b = y_ff;
      end else begin
         m0a = zr_ff; m0b = zr_ff;
         m1a = zi_ff; m1b = zi_ff;
      end
   end

   logic signed [FX_W-1:0] r2, i2, ri;
   assign r2 = fx_scale(p0_ff);
   assign i2 = fx_scale(p1_ff);
   assign ri = fx_scale(p2_ff);

   // final bytes
   rsp_type color;
   always_comb begin
      color.iteration_count = n_ff;
      color.blue  = '0;
      color.green = '0;
      color.red   = '0;
      if (maxit_ff >= ITER_W'(2) && n_ff != maxit_ff) begin
         unique case (seg_ff)
            3'd0: begin
               color.blue = pq_ff + 8'd128; color.green = qq_ff; color.red = 8'd0;
            end
            3'd1: begin
               color.blue = 8'd255; color.green = 8'd255; color.red = pq_ff;
            end
            3'd2: begin
               color.blue = pq_ff; color.green = 8'd255; color.red = 8'd255;
            end
            3'd3: begin
               color.blue = 8'd0; color.green = pq_ff + 8'd128; color.red = 8'd255;
            end
            3'd4: begin
               color.blue = 8'd0; color.green = pq_ff + 8'd64; color.red = qq_ff + 8'd128;
            end
            3'd5: begin
               color.blue = pq_ff; color.green = 8'd64; color.red = 8'd128;
            end
            default: begin
               color.blue = 8'd128; color.green = pq_ff; color.red = qq_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      p0_ff <= m0a * m0b;
      p1_ff <= m1a * m1b;
      p2_ff <= zr_ff * zi_ff;
      if (cmd.load) req_ff <= req_data;
      if (cmd.setup) begin
         wc_ff    <= PROD_W'(w_side) * PROD_W'(req_ff.column);
         den_a_ff <= DEN_W'(h_side) * DEN_W'(w_side - SIDE_W'(1));
      end
      if (cmd.div_wait && div_done) begin
         unique case (cmd.div_sel)
            DIV_A:   x_ff <= sat32(quot_ext - FX_ONE);
            DIV_B:   y_ff <= sat32(FX_HALF - quot_ext);
            DIV_SEG: begin
               seg_ff <= div_quot[2:0];
               r_ff   <= div_rem[ITER_W-1:0];
            end
            DIV_P:   pq_ff <= div_quot[BYTE_W-1:0];
            default: qq_ff <= div_quot[BYTE_W-1:0];
         endcase
      end
      if (cmd.sat_c) begin
         cr_ff   <= r2;
         ci_ff   <= i2;
         zr_ff   <= '0;
         zi_ff   <= '0;
         quad_ff <= '0;
         n_ff    <= ITER_W'(1);
      end
      if (cmd.iter_add) begin
         quad_ff <= sat_add(r2, i2);
         zr_ff   <= sat_add(sat_add(r2, -i2 == i2 && i2 != 0 ? i2 : -i2), cr_ff);
         zi_ff   <= sat_add(sat_add(ri, ri), ci_ff);
         n_ff    <= n_ff + ITER_W'(1);
      end
      if (cmd.color) rsp_ff <= color;
   end

   assign status.div_done = div_done;
   assign status.iter_go  = (n_ff < maxit_ff) && (quad_ff < $signed({1'b0, limit_ff}));
   assign rsp_data        = rsp_ff;

`ifndef ASSERT_OFF
   a_quad_nonneg: assert property (@(posedge clock) disable iff (reset)
      cmd.iter_add |=> quad_ff >= 0)
      else $error("squared magnitude went negative");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.iter_add |=> n_ff == $past(n_ff) + ITER_W'(1))
      else $error("pass counter did not step by one");
`endif

endmodule

// ----- rtl/mpc_ctrl.sv -----
// Controller: sequences setup divisions, c scaling, escape passes and the color ramp.
// Depends on mpc_pkg.
module mpc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output mpc_pkg::cmd_type    cmd,
   input  mpc_pkg::status_type status
);
   import mpc_pkg::*;

   typedef enum logic [18:0] {
      S_IDLE     = 19'h00001,
      S_SETUP    = 19'h00002,
      S_DIV_A    = 19'h00004,
      S_WAIT_A   = 19'h00008,
      S_DIV_B    = 19'h00010,
      S_WAIT_B   = 19'h00020,
      S_MUL_C    = 19'h00040,
      S_SAT_C    = 19'h00080,
      S_CHECK    = 19'h00100,
      S_ITER_MUL = 19'h00200,
      S_ITER_ADD = 19'h00400,
      S_DIV_SEG  = 19'h00800,
      S_WAIT_SEG = 19'h01000,
      S_DIV_P    = 19'h02000,
      S_WAIT_P   = 19'h04000,
      S_DIV_Q    = 19'h08000,
      S_WAIT_Q   = 19'h10000,
      S_COLOR    = 19'h20000,
      S_DONE     = 19'h40000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (start) state_in = S_SETUP;
         S_SETUP:    state_in = S_DIV_A;
         S_DIV_A:    state_in = S_WAIT_A;
         S_WAIT_A:   if (status.div_done) state_in = S_DIV_B;
         S_DIV_B:    state_in = S_WAIT_B;
         S_WAIT_B:   if (status.div_done) state_in = S_MUL_C;
         S_MUL_C:    state_in = S_SAT_C;
         S_SAT_C:    state_in = S_CHECK;
         S_CHECK:    state_in = status.iter_go ? S_ITER_MUL : S_DIV_SEG;
         S_ITER_MUL: state_in = S_ITER_ADD;
         S_ITER_ADD: state_in = S_CHECK;
         S_DIV_SEG:  state_in = S_WAIT_SEG;
         S_WAIT_SEG: if (status.div_done) state_in = S_DIV_P;
         S_DIV_P:    state_in = S_WAIT_P;
         S_WAIT_P:   if (status.div_done) state_in = S_DIV_Q;
         S_DIV_Q:    state_in = S_WAIT_Q;
         S_WAIT_Q:   if (status.div_done) state_in = S_COLOR;
         S_COLOR:    state_in = S_DONE;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      cmd.load      = (state_ff == S_IDLE) && start;
      cmd.setup     = state_ff == S_SETUP;
      cmd.div_start = (state_ff == S_DIV_A) || (state_ff == S_DIV_B) ||
                      (state_ff == S_DIV_SEG) || (state_ff == S_DIV_P) ||
                      (state_ff == S_DIV_Q);
      cmd.div_wait  = (state_ff == S_WAIT_A) || (state_ff == S_WAIT_B) ||
                      (state_ff == S_WAIT_SEG) || (state_ff == S_WAIT_P) ||
                      (state_ff == S_WAIT_Q);
      if ((state_ff == S_DIV_A) || (state_ff == S_WAIT_A)) cmd.div_sel = DIV_A;
      else if ((state_ff == S_DIV_B) || (state_ff == S_WAIT_B)) cmd.div_sel = DIV_B;
      else if ((state_ff == S_DIV_SEG) || (state_ff == S_WAIT_SEG)) cmd.div_sel = DIV_SEG;
      else if ((state_ff == S_DIV_P) || (state_ff == S_WAIT_P)) cmd.div_sel = DIV_P;
      else cmd.div_sel = DIV_Q;
      cmd.mul_c     = state_ff == S_MUL_C;
      cmd.sat_c     = state_ff == S_SAT_C;
      cmd.iter_add  = state_ff == S_ITER_ADD;
      cmd.color     = state_ff == S_COLOR;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_DONE;

`ifndef ASSERT_OFF
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (state_ff == S_IDLE))
      else $error("result strobe longer than one cycle");
   a_start: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == S_IDLE) |=> (state_ff == S_SETUP))
      else $error("accepted item did not start setup");
   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> cmd.div_wait)
      else $error("divider finished outside a wait state");
   a_pass_back: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ITER_ADD) |=> (state_ff == S_CHECK))
      else $error("escape pass did not return to check");
`endif

endmodule

// ----- rtl/mandelbrot_pixel_color.sv -----
// Top level of the Mandelbrot pixel color block: controller plus datapath.
// Depends on mpc_pkg, mpc_ctrl, mpc_datapath (and mpc_divider below it).
//
// Use:
//   Input: drive req_data (column, row) and raise start; the item is taken at
//   a rising edge with start high and busy low. busy stays high until the
//   result has been shown.
//   Output: rsp_valid is high for exactly one cycle with rsp_data holding the
//   final pass count and the blue, green and red bytes. The receiver cannot
//   stall; it must take the item in that cycle.
//   Config: csr_valid/csr_ready with csr_index and csr_data; csr_ready is
//   always high. Indexes: width, height, zoom, escape limit, max iterations.
//   Write only while busy is low.
// Sequence: one item at a time; once the result has been shown and busy is low
//   again, the next item can be taken. Most of the time goes to the shared
//   bit-serial divider: 49 steps for the column mapping, 36 for the row, 10
//   for the ramp segment and 15 for each of two ramp bytes. Each escape pass
//   steps through test, products and update.
// Reset: synchronous, active high; returns to idle and loads the default
//   configuration (640x480, zoom 1.5, limit 3.0, 40 iterations).
module mandelbrot_pixel_color (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  mpc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output mpc_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mpc_pkg::CSR_DATA_W-1:0] csr_data
);
   import mpc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // config is taken at any time; writes are only legal while idle
   assign csr_ready = 1'b1;

   mpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   mpc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

// ----- test/tb_mandelbrot_pixel_color.sv -----
// Testbench for mandelbrot_pixel_color: sends pixel positions under several register
// settings and checks every pixel color against a built-in escape-time predictor.
// Depends on mpc_pkg and the mandelbrot_pixel_color RTL.
`timescale 1ns / 1ps

module tb_mandelbrot_pixel_color;
   import mpc_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam longint FX_UNIT = 64'sd1 <<< FRAC_BITS;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   mandelbrot_pixel_color dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // shadow copy of the register file, reset values
   logic [12:0] cfg_width  = 13'd640;
   logic [12:0] cfg_height = 13'd480;
   logic [30:0] cfg_zoom   = 31'd25165824;
   logic [30:0] cfg_limit  = 31'd50331648;
   logic [6:0]  cfg_iters  = 7'd40;

   rsp_type pending_colors[$];
   int error_count = 0;
   int stall_cycles = 0;
   bit quiet_stretch = 0;   // no idle gaps while set

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic longint saturate(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // product rounded toward minus infinity, then saturated
   function automatic longint q_mul(longint x, longint y);
      return saturate((x * y) >>> FRAC_BITS);
   endfunction

   function automatic longint side_of(logic [12:0] s);
      if (s < 13'd2) return 2;
      if (s > 13'(MAX_SIDE)) return MAX_SIDE;
      return longint'(s);
   endfunction

   function automatic rsp_type predict_color(logic [11:0] col, logic [11:0] row);
      longint w, h, a, b, cr, ci, zr, zi, quad, r2, i2, ri;
      int unsigned n, len, seg, rem, inv, bl, gr, rd;
      rsp_type p;
      w = side_of(cfg_width);
      h = side_of(cfg_height);
      a = ((w * longint'(col)) <<< FRAC_BITS) / (h * (w - 1));
      cr = q_mul(longint'(cfg_zoom), saturate(a - FX_UNIT));
      b = (longint'(row) <<< FRAC_BITS) / (h - 1);
      ci = q_mul(longint'(cfg_zoom), saturate(FX_UNIT / 2 - b));
      zr = 0; zi = 0; quad = 0; n = 1;
      len = cfg_iters;
      while (n < len && quad < longint'(cfg_limit)) begin
         r2 = q_mul(zr, zr);
         i2 = q_mul(zi, zi);
         ri = q_mul(zr, zi);
         quad = saturate(r2 + i2);
         zr = saturate(saturate(r2 - i2) + cr);
         zi = saturate(saturate(2 * ri) + ci);
         n++;
      end
      bl = 0; gr = 0; rd = 0;
      if (len >= 2 && n != len) begin
         seg = (7 * n) / len;
         rem = (7 * n) % len;
         inv = len - rem;
         case (seg)
            0: begin bl = 127*rem/len + 128; gr = 255*rem/len; end
            1: begin bl = 255; gr = 255; rd = 255*rem/len; end
            2: begin bl = 255*inv/len; gr = 255; rd = 255; end
            3: begin gr = 127*inv/len + 128; rd = 255; end
            4: begin gr = 63*inv/len + 64; rd = 127*inv/len + 128; end
            5: begin bl = 128*rem/len; gr = 64; rd = 128; end
            default: begin bl = 128; gr = 64*inv/len; rd = 128*inv/len; end
         endcase
      end
      p.iteration_count = n[6:0];
      p.blue = bl[7:0];
      p.green = gr[7:0];
      p.red = rd[7:0];
      return p;
   endfunction

   // ---------------- shared tasks ----------------
   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // random idle gap of the sender, taken before about one item in ten
   task automatic idle_gap();
      while (!quiet_stretch && $urandom_range(0, 9) == 0) @(posedge clock);
   endtask

   // one pixel item: raise start, hold until taken, then log its expected color
   task automatic send_pixel(logic [11:0] col, logic [11:0] row);
      idle_gap();
      @(posedge clock);
      start <= 1'b1;
      req_data <= '{column: col, row: row};
      do @(posedge clock); while (busy);
      pending_colors.push_back(predict_color(col, row));
      start <= 1'b0;
   endtask

   // register writes only with the block idle and no color still due
   task automatic write_reg(csr_index_type idx, logic [30:0] value);
      while (pending_colors.size() != 0 || busy) @(posedge clock);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:    cfg_width  = value[12:0];
         CSR_IMAGE_HEIGHT:   cfg_height = value[12:0];
         CSR_ZOOM_SCALE:     cfg_zoom   = value;
         CSR_ESCAPE_LIMIT:   cfg_limit  = value;
         CSR_MAX_ITERATIONS: cfg_iters  = value[6:0];
         default: ;
      endcase
   endtask

   task automatic write_all(logic [12:0] w, logic [12:0] h, logic [30:0] z,
                            logic [30:0] lim, logic [6:0] it);
      write_reg(CSR_IMAGE_WIDTH, 31'(w));
      write_reg(CSR_IMAGE_HEIGHT, 31'(h));
      write_reg(CSR_ZOOM_SCALE, z);
      write_reg(CSR_ESCAPE_LIMIT, lim);
      write_reg(CSR_MAX_ITERATIONS, 31'(it));
   endtask

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_colors.size() == 0) begin
            report_mismatch("color item with nothing expected");
         end else begin
            want = pending_colors.pop_front();
            if (rsp_data.iteration_count !== want.iteration_count)
               report_mismatch($sformatf("iteration_count %0d, want %0d",
                               rsp_data.iteration_count, want.iteration_count));
            if (rsp_data.blue !== want.blue)
               report_mismatch($sformatf("blue %0d, want %0d", rsp_data.blue, want.blue));
            if (rsp_data.green !== want.green)
               report_mismatch($sformatf("green %0d, want %0d", rsp_data.green, want.green));
            if (rsp_data.red !== want.red)
               report_mismatch($sformatf("red %0d, want %0d", rsp_data.red, want.red));
         end
      end
   end

   // watchdog: cycles with no item taken on any port
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------- tests ----------------
   // reset config: image corners, a point on the middle row, and positions past the edge
   task automatic test_default_corners();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd639, 12'd479);
      send_pixel(12'd0, 12'd479);
      send_pixel(12'd639, 12'd0);
      send_pixel(12'd213, 12'd240);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
   endtask

   // side clamping, iteration cap below two, zero limit, scale extremes
   task automatic test_register_extremes();
      write_all(13'd0, 13'd8191, 31'd25165824, 31'd50331648, 7'd127);
      send_pixel(12'd1, 12'd4095);
      send_pixel(12'd4095, 12'd2048);
      write_all(13'd4096, 13'd1, 31'h7FFFFFFF, 31'h7FFFFFFF, 7'd0);
      send_pixel(12'd2048, 12'd1);
      write_reg(CSR_MAX_ITERATIONS, 31'd1);
      send_pixel(12'd100, 12'd0);
      write_reg(CSR_MAX_ITERATIONS, 31'd127);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd0);
      write_all(13'd2, 13'd2, 31'd0, 31'd0, 7'd2);
      send_pixel(12'd1, 12'd1);
      write_reg(CSR_ESCAPE_LIMIT, 31'd67108864);
      send_pixel(12'd0, 12'd1);
      write_all(13'd640, 13'd480, 31'd25165824, 31'd50331648, 7'd40);
      send_pixel(12'd300, 12'd240);
   endtask

   // random configs, mostly in-image positions; one phase runs without gaps
   task automatic test_random_phases();
      logic [12:0] w, h;
      logic [30:0] z, lim;
      logic [6:0] it;
      int count;
      for (int phase = 0; phase < 13; phase++) begin
         w = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(2, 800));
         h = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(2, 600));
         z = ($urandom_range(0, 5) == 0) ? 31'($urandom)
                                          : 31'($urandom_range(8388608, 50331648));
         lim = ($urandom_range(0, 5) == 0) ? 31'($urandom)
                                            : 31'($urandom_range(16777216, 67108864));
         it = ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(2, 48));
         write_all(w, h, z, lim, it);
         quiet_stretch = (phase == 4);
         count = 110;
         for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 6) == 0)
               send_pixel(12'($urandom), 12'($urandom));
            else
               send_pixel(12'($urandom_range(0, side_of(w) - 1)),
                          12'($urandom_range(0, side_of(h) - 1)));
         end
         quiet_stretch = 0;
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_default_corners();
      test_register_extremes();
      test_random_phases();

      while (pending_colors.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
